// ===== design/btu_pkg.sv =====
`default_nettype none

package btu_pkg;

    localparam int BUF_BITS    = 48;
    localparam int SAMPLE_BITS = 32;
    localparam int END_BITS    = 12;
    localparam int WCODE_BITS  = 6;

    localparam logic [11:0] TOTAL_CAP   = 12'd2048;
    localparam logic [5:0]  MAX_WIDTH   = 6'd32;
    localparam logic [3:0]  LAST_BAND   = 4'd14;
    localparam logic [4:0]  MAX_RESULTS = 5'd16;

    localparam logic [47:0] WIDTHS_LO_RESET = 48'd71485708370960;
    localparam logic [41:0] WIDTHS_HI_RESET = 42'd1116964193296;

    localparam logic [2:0] REG_ENDS_A    = 3'd0;
    localparam logic [2:0] REG_ENDS_B    = 3'd1;
    localparam logic [2:0] REG_ENDS_C    = 3'd2;
    localparam logic [2:0] REG_ENDS_D    = 3'd3;
    localparam logic [2:0] REG_TOTAL     = 3'd4;
    localparam logic [2:0] REG_WIDTHS_LO = 3'd5;
    localparam logic [2:0] REG_WIDTHS_HI = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETTLE_PRE,
        ST_LOAD,
        ST_CHECK,
        ST_SHIFT,
        ST_SETTLE_POST
    } btu_state_t;

    typedef struct packed {
        logic frame_clear;
        logic word_capture;
        logic settle_en;
        logic buf_load;
        logic bit_shift;
        logic samp_start;
        logic count_inc;
    } btu_ctrl_t;

    typedef struct packed {
        logic        settled;
        logic        done;
        logic [5:0]  width;
        logic [3:0]  band;
        logic [11:0] count;
    } btu_band_stat_t;

    typedef struct packed {
        logic [5:0] bits;
        logic       head_bit;
        logic       fits;
        logic       load_last;
    } btu_buf_stat_t;

endpackage

`default_nettype wire

// ===== design/btu_band_ctrl.sv =====
`default_nettype none

module btu_band_ctrl
    import btu_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [47:0]    cfg_data,
    input  wire btu_ctrl_t      ctrl,
    output btu_band_stat_t      stat
);

    logic [47:0] ends_a_reg, ends_b_reg, ends_c_reg;
    logic [35:0] ends_d_reg;
    logic [11:0] total_reg;
    logic [47:0] widths_lo_reg;
    logic [41:0] widths_hi_reg;

    logic [3:0]  band_reg, band_next;
    logic [11:0] count_reg, count_next;
    logic        done_reg, done_next;

    logic [11:0] ends [16];
    logic [5:0]  wcodes [16];
    logic [11:0] band_end;
    logic [11:0] total;
    logic [11:0] limit;
    logic [5:0]  wcode;
    logic        settled;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ends_a_reg    <= '0;
            ends_b_reg    <= '0;
            ends_c_reg    <= '0;
            ends_d_reg    <= '0;
            total_reg     <= '0;
            widths_lo_reg <= WIDTHS_LO_RESET;
            widths_hi_reg <= WIDTHS_HI_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENDS_A:    ends_a_reg    <= cfg_data;
                REG_ENDS_B:    ends_b_reg    <= cfg_data;
                REG_ENDS_C:    ends_c_reg    <= cfg_data;
                REG_ENDS_D:    ends_d_reg    <= cfg_data[35:0];
                REG_TOTAL:     total_reg     <= cfg_data[11:0];
                REG_WIDTHS_LO: widths_lo_reg <= cfg_data;
                REG_WIDTHS_HI: widths_hi_reg <= cfg_data[41:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            ends[k]      = ends_a_reg[END_BITS*k +: END_BITS];
            ends[k + 4]  = ends_b_reg[END_BITS*k +: END_BITS];
            ends[k + 8]  = ends_c_reg[END_BITS*k +: END_BITS];
        end
        for (int k = 0; k < 3; k++)
        begin
            ends[k + 12] = ends_d_reg[END_BITS*k +: END_BITS];
        end
        ends[15] = '0;
        for (int k = 0; k < 8; k++)
        begin
            wcodes[k] = widths_lo_reg[WCODE_BITS*k +: WCODE_BITS];
        end
        for (int k = 0; k < 7; k++)
        begin
            wcodes[k + 8] = widths_hi_reg[WCODE_BITS*k +: WCODE_BITS];
        end
        wcodes[15] = '0;
    end

    assign total    = (total_reg > TOTAL_CAP) ? TOTAL_CAP : total_reg;
    assign band_end = ends[band_reg];
    assign limit    = (band_end < total) ? band_end : total;
    assign settled  = done_reg || (count_reg < limit);
    assign wcode    = wcodes[band_reg];

    always_comb
    begin
        band_next  = band_reg;
        count_next = count_reg;
        done_next  = done_reg;
        if (ctrl.frame_clear)
        begin
            band_next  = '0;
            count_next = '0;
            done_next  = 1'b0;
        end
        else if (ctrl.count_inc)
        begin
            count_next = count_reg + 12'd1;
        end
        else if (ctrl.settle_en && !settled)
        begin
            // One band is examined per cycle; the frame closes at the total or the last band.
            if ((band_end >= total) || (band_reg >= LAST_BAND))
            begin
                done_next = 1'b1;
            end
            else
            begin
                band_next = band_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b1;
        end
        else
        begin
            band_reg  <= band_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        stat.settled = settled;
        stat.done    = done_reg;
        stat.band    = band_reg;
        stat.count   = count_reg;
        if (wcode == 6'd0)
        begin
            stat.width = 6'd1;
        end
        else if (wcode > MAX_WIDTH)
        begin
            stat.width = MAX_WIDTH;
        end
        else
        begin
            stat.width = wcode;
        end
    end

endmodule

`default_nettype wire

// ===== design/btu_bit_buffer.sv =====
`default_nettype none

module btu_bit_buffer
    import btu_pkg::*;
#(
    parameter int WORD_BITS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire btu_ctrl_t            ctrl,
    input  wire logic [WORD_BITS-1:0] packed_word,
    output btu_buf_stat_t             stat
);

    localparam int LCNT_W = $clog2(WORD_BITS);

    logic [BUF_BITS-1:0]  buf_reg, buf_next;
    logic [5:0]           bits_reg, bits_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic [LCNT_W-1:0]    lcnt_reg, lcnt_next;

    always_comb
    begin
        buf_next  = buf_reg;
        bits_next = bits_reg;
        word_next = word_reg;
        lcnt_next = lcnt_reg;
        if (ctrl.word_capture)
        begin
            word_next = packed_word;
            lcnt_next = '0;
        end
        if (ctrl.frame_clear)
        begin
            buf_next  = '0;
            bits_next = '0;
        end
        else if (ctrl.buf_load)
        begin
            // The word enters one bit per cycle just above the bits still held.
            for (int j = 0; j < BUF_BITS; j++)
            begin
                if (6'(j) == bits_reg)
                begin
                    buf_next[j] = word_reg[0];
                end
            end
            bits_next = bits_reg + 6'd1;
            word_next = word_reg >> 1;
            lcnt_next = lcnt_reg + LCNT_W'(1);
        end
        else if (ctrl.bit_shift)
        begin
            buf_next  = buf_reg >> 1;
            bits_next = bits_reg - 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= '0;
            lcnt_reg <= '0;
        end
        else
        begin
            bits_reg <= bits_next;
            lcnt_reg <= lcnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg <= '0;
        end
        else
        begin
            buf_reg <= buf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign stat.bits      = bits_reg;
    assign stat.head_bit  = buf_reg[0];
    assign stat.fits      = ({1'b0, bits_reg} + 7'(WORD_BITS)) <= 7'(BUF_BITS);
    assign stat.load_last = (lcnt_reg == LCNT_W'(WORD_BITS - 1));

endmodule

`default_nettype wire

// ===== design/btu_sample_asm.sv =====
`default_nettype none

module btu_sample_asm
    import btu_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire btu_ctrl_t               ctrl,
    input  wire logic                    head_bit,
    input  wire logic [5:0]              width,
    output logic signed [SAMPLE_BITS-1:0] value,
    output logic                         last_bit
);

    logic [SAMPLE_BITS-1:0] samp_reg, samp_next;
    logic [4:0]             idx_reg, idx_next;

    always_comb
    begin
        samp_next = samp_reg;
        idx_next  = idx_reg;
        if (ctrl.samp_start)
        begin
            idx_next = '0;
        end
        else if (ctrl.bit_shift)
        begin
            // Each bit also fills every place above it, so the top bit ends as the sign.
            for (int j = 0; j < SAMPLE_BITS; j++)
            begin
                if (5'(j) >= idx_reg)
                begin
                    samp_next[j] = head_bit;
                end
            end
            idx_next = idx_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_reg <= samp_next;
    end

    assign value    = samp_reg;
    assign last_bit = ({1'b0, idx_reg} == (width - 6'd1));

endmodule

`default_nettype wire

// ===== design/btu_seq.sv =====
`default_nettype none

module btu_seq
    import btu_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     frame_start,
    input  wire btu_band_stat_t           bstat,
    input  wire btu_buf_stat_t            fstat,
    input  wire logic signed [SAMPLE_BITS-1:0] samp_value,
    input  wire logic                     samp_last,
    output btu_ctrl_t                     ctrl,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [SAMPLE_BITS-1:0] sample,
    output logic [10:0]                   sample_index,
    output logic [3:0]                    band_number,
    output logic                          run_last,
    output logic                          frame_last
);

    btu_state_t state_reg, state_next;

    logic [4:0]  n_reg, n_next;
    logic        pend_reg, pend_next;
    logic [10:0] pend_index_reg, pend_index_next;
    logic [3:0]  pend_band_reg, pend_band_next;
    logic        pend_flast_reg, pend_flast_next;

    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] out_sample_reg, out_sample_next;
    logic [10:0]            out_index_reg, out_index_next;
    logic [3:0]             out_band_reg, out_band_next;
    logic                   out_rlast_reg, out_rlast_next;
    logic                   out_flast_reg, out_flast_next;

    logic accept;
    logic slot_free;
    logic more;
    logic push;
    logic go_shift;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign more      = (n_reg < MAX_RESULTS) && !bstat.done && (fstat.bits >= bstat.width);
    // The waiting sample learns whether it closes the run only once the next one is known.
    assign push      = (state_reg == ST_CHECK) && pend_reg && slot_free;
    assign go_shift  = (state_reg == ST_CHECK) && (!pend_reg || slot_free) && more;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SETTLE_PRE;
                end
            end
            ST_SETTLE_PRE:
            begin
                if (bstat.settled)
                begin
                    if (bstat.done)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (fstat.fits)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_LOAD:
            begin
                if (fstat.load_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!pend_reg || slot_free)
                begin
                    state_next = more ? ST_SHIFT : ST_IDLE;
                end
            end
            ST_SHIFT:
            begin
                if (samp_last)
                begin
                    state_next = ST_SETTLE_POST;
                end
            end
            ST_SETTLE_POST:
            begin
                if (bstat.settled)
                begin
                    state_next = ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl.frame_clear  = accept && frame_start;
        ctrl.word_capture = accept;
        ctrl.settle_en    = (state_reg == ST_SETTLE_PRE) || (state_reg == ST_SETTLE_POST);
        ctrl.buf_load     = (state_reg == ST_LOAD);
        ctrl.bit_shift    = (state_reg == ST_SHIFT);
        ctrl.samp_start   = go_shift;
        ctrl.count_inc    = (state_reg == ST_SHIFT) && samp_last;

        n_next          = n_reg;
        pend_next       = pend_reg;
        pend_index_next = pend_index_reg;
        pend_band_next  = pend_band_reg;
        pend_flast_next = pend_flast_reg;
        if (accept)
        begin
            n_next = '0;
        end
        if (go_shift)
        begin
            pend_index_next = bstat.count[10:0];
            pend_band_next  = bstat.band;
        end
        if (ctrl.count_inc)
        begin
            n_next    = n_reg + 5'd1;
            pend_next = 1'b1;
        end
        else if (push)
        begin
            pend_next = 1'b0;
        end
        if ((state_reg == ST_SETTLE_POST) && bstat.settled)
        begin
            pend_flast_next = bstat.done;
        end

        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        out_index_next  = out_index_reg;
        out_band_next   = out_band_reg;
        out_rlast_next  = out_rlast_reg;
        out_flast_next  = out_flast_reg;
        if (push)
        begin
            out_valid_next  = 1'b1;
            out_sample_next = samp_value;
            out_index_next  = pend_index_reg;
            out_band_next   = pend_band_reg;
            out_rlast_next  = !more;
            out_flast_next  = pend_flast_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_index_reg <= pend_index_next;
        pend_band_reg  <= pend_band_next;
        pend_flast_reg <= pend_flast_next;
        out_sample_reg <= out_sample_next;
        out_index_reg  <= out_index_next;
        out_band_reg   <= out_band_next;
        out_rlast_reg  <= out_rlast_next;
        out_flast_reg  <= out_flast_next;
    end

    assign out_valid    = out_valid_reg;
    assign sample       = out_sample_reg;
    assign sample_index = out_index_reg;
    assign band_number  = out_band_reg;
    assign run_last     = out_rlast_reg;
    assign frame_last   = out_flast_reg;

endmodule

`default_nettype wire

// ===== design/bit_trim_unpacker.sv =====
// Variable-width bit-field unpacker. Packed words form one continuous stream, bit 0 first;
// signed samples are cut from it at a width set per band (bands given by cumulative end
// counts in the ends registers, the frame by the total register), sign-extended to 32 bits
// and delivered with their index, band, a run_last mark on the final sample a word yields
// and a frame_last mark on the final sample of the frame. A request with frame_start set
// opens a new frame; words after the frame ends are dropped. All data moves through one
// bit-serial path: each word is checked and then shifted bit by bit into the 48-bit buffer,
// each sample is then shifted out of it bit by bit, and the settle states step past any
// band that is passed over. A new request is taken once the previous word is fully
// unpacked, while the last sample may still sit in the output register.
`default_nettype none

module bit_trim_unpacker
    import btu_pkg::*;
#(
    parameter int WORD_BITS = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [2:0]               cfg_index,
    input  wire logic [47:0]              cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     frame_start,
    input  wire logic [WORD_BITS-1:0]     packed_word,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [SAMPLE_BITS-1:0] sample,
    output logic [10:0]                   sample_index,
    output logic [3:0]                    band_number,
    output logic                          run_last,
    output logic                          frame_last
);

    btu_ctrl_t      ctrl;
    btu_band_stat_t bstat;
    btu_buf_stat_t  fstat;

    logic signed [SAMPLE_BITS-1:0] samp_value;
    logic                          samp_last;

    btu_band_ctrl u_band_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl),
        .stat      (bstat)
    );

    btu_bit_buffer #(
        .WORD_BITS (WORD_BITS)
    ) u_bit_buffer (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .packed_word (packed_word),
        .stat        (fstat)
    );

    btu_sample_asm u_sample_asm (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .head_bit (fstat.head_bit),
        .width    (bstat.width),
        .value    (samp_value),
        .last_bit (samp_last)
    );

    btu_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .frame_start  (frame_start),
        .bstat        (bstat),
        .fstat        (fstat),
        .samp_value   (samp_value),
        .samp_last    (samp_last),
        .ctrl         (ctrl),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample       (sample),
        .sample_index (sample_index),
        .band_number  (band_number),
        .run_last     (run_last),
        .frame_last   (frame_last)
    );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import btu_pkg::*;

    localparam int WORD_BITS    = 16;
    localparam int LATENCY_PAD  = 200;
    localparam int HOLD_CYCLES  = 500;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int NUM_PHASES   = 14;
    localparam int NUM_DIRECTED = 20;

    localparam logic [2:0] REG_ORDER [7] = '{REG_ENDS_A, REG_ENDS_B, REG_ENDS_C, REG_ENDS_D,
                                            REG_TOTAL, REG_WIDTHS_LO, REG_WIDTHS_HI};

    localparam logic [15:0] DIRECTED_WORDS [NUM_DIRECTED] = '{
        16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA,
        16'h8001, 16'hFFFE, 16'h0000, 16'hFFFF, 16'h1234, 16'h8000, 16'hC3A5, 16'h0F0F,
        16'h7FFF, 16'h0000, 16'hFFFF, 16'h8421};

    typedef enum int {PH_RANDOM, PH_LONG, PH_WIDE, PH_EMPTY} phase_kind_t;

    typedef logic [47:0] reg_image_t [7];

    typedef struct {
        logic [31:0] value;
        logic [10:0] index;
        logic [3:0]  band;
        logic        run_end;
        logic        frame_end;
    } unpacked_sample_t;

    class sample_checker;
        logic [47:0] ends_a, ends_b, ends_c;
        logic [35:0] ends_d;
        logic [11:0] total_reg;
        logic [47:0] widths_lo;
        logic [41:0] widths_hi;

        logic [63:0] bits;
        int unsigned bit_count;
        int unsigned sample_no;
        int unsigned band;
        bit          frame_closed;

        unpacked_sample_t expected_samples[$];
        int errors;

        function new();
            ends_a = '0;
            ends_b = '0;
            ends_c = '0;
            ends_d = '0;
            total_reg = '0;
            widths_lo = WIDTHS_LO_RESET;
            widths_hi = WIDTHS_HI_RESET;
            bits = '0;
            bit_count = 0;
            sample_no = 0;
            band = 0;
            frame_closed = 1'b1;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [47:0] data);
            case (idx)
                REG_ENDS_A:    ends_a = data;
                REG_ENDS_B:    ends_b = data;
                REG_ENDS_C:    ends_c = data;
                REG_ENDS_D:    ends_d = data[35:0];
                REG_TOTAL:     total_reg = data[11:0];
                REG_WIDTHS_LO: widths_lo = data;
                REG_WIDTHS_HI: widths_hi = data[41:0];
                default: ;
            endcase
        endfunction

        function int unsigned band_limit(int unsigned b);
            logic [47:0] r;
            int unsigned s;
            b = b & 15;
            if (b < 4)
            begin
                r = ends_a;
                s = b;
            end
            else if (b < 8)
            begin
                r = ends_b;
                s = b - 4;
            end
            else if (b < 12)
            begin
                r = ends_c;
                s = b - 8;
            end
            else
            begin
                r = 48'(ends_d);
                s = b - 12;
            end
            return 32'((r >> (END_BITS * s)) & 48'hFFF);
        endfunction

        function int unsigned band_width(int unsigned b);
            int unsigned w;
            b = b & 15;
            if (b < 8)
                w = 32'((widths_lo >> (WCODE_BITS * b)) & 48'h3F);
            else
                w = 32'((widths_hi >> (WCODE_BITS * (b - 8))) & 42'h3F);
            if (w == 0)
                w = 1;
            if (w > MAX_WIDTH)
                w = 32'(MAX_WIDTH);
            return w;
        endfunction

        function int unsigned capped_total();
            return 32'((total_reg > TOTAL_CAP) ? TOTAL_CAP : total_reg);
        endfunction

        // Steps past bands that are already complete and closes the frame where it ends.
        function void advance_bands();
            int unsigned t, e, lim;
            t = capped_total();
            while (!frame_closed) begin
                e = band_limit(band);
                lim = (e < t) ? e : t;
                if (sample_no < lim)
                    break;
                if (e >= t || band >= LAST_BAND) begin
                    frame_closed = 1'b1;
                    break;
                end
                band++;
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction

        function void take_word(logic start, logic [WORD_BITS-1:0] word);
            unpacked_sample_t run[$];
            unpacked_sample_t e;
            logic [63:0] v, mask;
            int unsigned w;
            if (start) begin
                bits = '0;
                bit_count = 0;
                sample_no = 0;
                band = 0;
                frame_closed = 1'b0;
            end
            advance_bands();
            if (frame_closed)
                return;
            // A word that would overflow the buffer is dropped.
            if (bit_count + WORD_BITS <= BUF_BITS) begin
                bits |= 64'(word) << bit_count;
                bit_count += WORD_BITS;
            end
            while (run.size() < MAX_RESULTS && !frame_closed) begin
                w = band_width(band);
                if (bit_count < w)
                    break;
                mask = (64'd1 << w) - 64'd1;
                v = bits & mask;
                bits = bits >> w;
                bit_count -= w;
                if (v[w-1])
                    v |= 64'hFFFF_FFFF ^ mask;
                e.value = v[31:0];
                e.index = sample_no[10:0];
                e.band = band[3:0];
                e.run_end = 1'b0;
                sample_no++;
                advance_bands();
                e.frame_end = frame_closed;
                run.push_back(e);
            end
            if (run.size() > 0)
                run[run.size()-1].run_end = 1'b1;
            foreach (run[i])
                expected_samples.push_back(run[i]);
        endfunction

        function void match_sample(logic [31:0] value, logic [10:0] index, logic [3:0] bnum,
                                   logic rl, logic fl);
            unpacked_sample_t e;
            if (expected_samples.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected sample %h index %0d band %0d run_last %b frame_last %b",
                             value, index, bnum, rl, fl);
                return;
            end
            e = expected_samples.pop_front();
            if (e.value !== value || e.index !== index || e.band !== bnum ||
                e.run_end !== rl || e.frame_end !== fl) begin
                errors++;
                if (errors <= 10)
                    $display("sample mismatch: expected %h/%0d/%0d/%b/%b, got %h/%0d/%0d/%b/%b",
                             e.value, e.index, e.band, e.run_end, e.frame_end,
                             value, index, bnum, rl, fl);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [47:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic frame_start;
    logic [WORD_BITS-1:0] packed_word;
    logic out_valid;
    logic out_ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [10:0] sample_index;
    logic [3:0] band_number;
    logic run_last;
    logic frame_last;

    sample_checker sb = new();
    bit tx_no_gaps = 1'b0;
    bit hold_wanted = 1'b0;
    int cycles = 0;

    bit_trim_unpacker #(.WORD_BITS(WORD_BITS)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .frame_start(frame_start),
        .packed_word(packed_word),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .sample(sample),
        .sample_index(sample_index),
        .band_number(band_number),
        .run_last(run_last),
        .frame_last(frame_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_no_gaps || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Called just after the clock rises; returns once the block has taken the request.
    task automatic offer_word(input logic start, input logic [WORD_BITS-1:0] word);
        in_valid <= 1'b1;
        frame_start <= start;
        packed_word <= word;
        do
            @(posedge clk);
        while (!in_ready);
        sb.take_word(start, word);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_regs(input reg_image_t img);
        for (int i = 0; i < 7; i++)
            write_reg(REG_ORDER[i], img[i]);
        cfg_we <= 1'b0;
    endtask

    // Words that yield no sample may still be in flight once the queue is empty.
    task automatic finish_phase();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LATENCY_PAD) @(posedge clk);
    endtask

    task automatic program_phase(input phase_kind_t kind);
        logic [11:0] ends [15];
        logic [5:0] widths [15];
        reg_image_t img;
        logic [63:0] noise;
        logic [11:0] tot;
        int cur;
        int r;
        cur = 0;
        noise = {$urandom(), $urandom()};
        for (int b = 0; b < 15; b++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                ends[b] = 12'($urandom_range(0, 4095));
            else
            begin
                cur += $urandom_range(0, 6);
                ends[b] = 12'(cur);
            end
            r = $urandom_range(0, 99);
            if (r < 8)
                widths[b] = 6'd0;
            else if (r < 16)
                widths[b] = 6'($urandom_range(33, 63));
            else if (r < 26)
                widths[b] = 6'($urandom_range(21, 32));
            else
                widths[b] = 6'($urandom_range(1, 12));
        end
        tot = ($urandom_range(0, 19) == 0) ? 12'd0 : 12'($urandom_range(1, 60));
        case (kind)
            PH_LONG:
            begin
                tot = TOTAL_CAP;
                foreach (ends[b])
                    ends[b] = 12'hFFF;
                foreach (widths[b])
                    widths[b] = 6'd0;
            end
            PH_WIDE:
                foreach (widths[b])
                    widths[b] = 6'h3F;
            PH_EMPTY:
                foreach (ends[b])
                    ends[b] = 12'd0;
            default: ;
        endcase
        img[REG_ENDS_A] = {ends[3], ends[2], ends[1], ends[0]};
        img[REG_ENDS_B] = {ends[7], ends[6], ends[5], ends[4]};
        img[REG_ENDS_C] = {ends[11], ends[10], ends[9], ends[8]};
        img[REG_ENDS_D] = {noise[11:0], ends[14], ends[13], ends[12]};
        img[REG_TOTAL] = {noise[47:12], tot};
        img[REG_WIDTHS_LO] = {widths[7], widths[6], widths[5], widths[4],
                              widths[3], widths[2], widths[1], widths[0]};
        img[REG_WIDTHS_HI] = {noise[53:48], widths[14], widths[13], widths[12], widths[11],
                              widths[10], widths[9], widths[8]};
        apply_regs(img);
    endtask

    // Receiver: random stalls, stretches of steady acceptance and a long hold-off whenever one is requested.
    initial
    begin
        int stall_left;
        int steady_left;
        int r;
        stall_left = 0;
        steady_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.match_sample(sample, sample_index, band_number, run_last, frame_last);
            if (hold_wanted)
            begin
                hold_wanted = 1'b0;
                stall_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (steady_left > 0)
            begin
                steady_left--;
                out_ready <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 2)
                begin
                    steady_left = $urandom_range(50, 200);
                    out_ready <= 1'b1;
                end
                else if (r < 70)
                    out_ready <= 1'b1;
                else if (r < 95)
                begin
                    stall_left = $urandom_range(0, 2);
                    out_ready <= 1'b0;
                end
                else
                begin
                    stall_left = $urandom_range(10, 60);
                    out_ready <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        reg_image_t img;
        phase_kind_t kind;
        int n_items;
        int counted;
        logic start;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_ENDS_A;
        cfg_data <= '0;
        in_valid <= 1'b0;
        frame_start <= 1'b0;
        packed_word <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Out of reset the block waits for a frame start, and a zero total ends a frame at once.
        offer_word(1'b0, 16'hFFFF);
        idle_gap(pick_gap());
        offer_word(1'b1, 16'h1234);
        finish_phase();

        // Width codes of zero and above the maximum, an empty band, a band end below the
        // current count and a last band end beyond the total.
        img[REG_ENDS_A] = {12'd24, 12'd22, 12'd20, 12'd20};
        img[REG_ENDS_B] = {12'd33, 12'd32, 12'd30, 12'd26};
        img[REG_ENDS_C] = {12'd37, 12'd36, 12'd35, 12'd34};
        img[REG_ENDS_D] = {12'd0, 12'd4095, 12'd38, 12'd10};
        img[REG_TOTAL] = 48'd40;
        img[REG_WIDTHS_LO] = {6'd12, 6'd7, 6'd1, 6'd16, 6'd32, 6'd63, 6'd5, 6'd0};
        img[REG_WIDTHS_HI] = {6'd0, 6'd20, 6'd6, 6'd4, 6'd8, 6'd33, 6'd2, 6'd3};
        apply_regs(img);
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            offer_word(i == 0, DIRECTED_WORDS[i]);
            idle_gap(pick_gap());
        end
        offer_word(1'b1, 16'hFFFF);
        finish_phase();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0: kind = PH_LONG;
                1: kind = PH_WIDE;
                2: kind = PH_EMPTY;
                default: kind = PH_RANDOM;
            endcase
            tx_no_gaps = (phase % 4 == 3);
            n_items = (kind == PH_LONG) ? 135 : (kind == PH_EMPTY) ? 8 : $urandom_range(12, 30);
            program_phase(kind);
            counted = 0;
            while (counted < n_items)
            begin
                // Mostly whole frames; now and then a word after the frame end or a restart.
                if (counted == 0)
                    start = ($urandom_range(0, 4) != 0);
                else if (sb.frame_closed)
                    start = ($urandom_range(0, 99) < 85);
                else
                    start = ($urandom_range(0, 99) < 4);
                if (start || !sb.frame_closed)
                    counted++;
                if ((kind == PH_LONG && counted == 60) || (phase == 6 && counted == 8))
                    hold_wanted = 1'b1;
                offer_word(start, WORD_BITS'($urandom_range(0, 65535)));
                if (counted < n_items)
                    idle_gap(pick_gap());
            end
            finish_phase();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
